@@ hw/rtl/tsfe_pkg.sv @@
`default_nettype none

package tsfe_pkg;

    // Fixed point format
    localparam int FRAC_BITS = 16;
    localparam int IN_W      = 18;
    localparam int OUT_W     = 20;
    localparam int NODE_W    = 4;

    // Last node number of each element type
    localparam logic [NODE_W-1:0] LAST_NODE_LIN  = NODE_W'(3);
    localparam logic [NODE_W-1:0] LAST_NODE_QUAD = NODE_W'(9);

    // Internal widths: one, coordinate sums, product operands, derivatives, products
    localparam int ONE_W = FRAC_BITS + 2;
    localparam int CW    = ((IN_W > ONE_W) ? IN_W : ONE_W) + 2;
    localparam int OW    = CW + 1;
    localparam int DW    = CW + 4;
    localparam int PW    = 2 * OW + 3;

    localparam logic signed [CW-1:0] ONE_C =
        {{(CW - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [PW-1:0] HALF_P =
        {{(PW - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
    localparam logic signed [PW-1:0] OUT_MAX_P =
        {{(PW - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
    localparam logic signed [PW-1:0] OUT_MIN_P =
        {{(PW - OUT_W + 1){1'b1}}, {(OUT_W - 1){1'b0}}};

    // Per-node control that travels with the data
    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic              last;
        logic              quad;
    } tsfe_tag_t;

    // Clamp a wide signed value to the output range
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [PW-1:0] v);
        logic signed [OUT_W-1:0] res;
        if (v > OUT_MAX_P) begin
            res = OUT_MAX_P[OUT_W-1:0];
        end else if (v < OUT_MIN_P) begin
            res = OUT_MIN_P[OUT_W-1:0];
        end else begin
            res = v[OUT_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tet_shape_function_eval_core.sv @@
// Channel   | Signals                                            | Handshake
// ----------+----------------------------------------------------+---------------------------
// request   | coord_r, coord_s, coord_t                          | start & !busy
// result    | node_index, shape_value, deriv_r/s/t, last_node    | result_valid, one cycle
// config    | cfg_data (quadratic_mode)                          | cfg_valid & cfg_ready
//
// One node result leaves per cycle: a request issues nodes 0-3 (linear) or 0-9 (quadratic)
// from the node sequencer, which sets the request rate; busy is low in a request's last
// issue cycle so the next request follows without a gap.
// The first result is registered in the node sequencer, then passes through the operand,
// multiply and round/clamp stages to the ports.
// Reset clears the mode to linear, the sequencer and the stage valid bits.
// The receiver cannot stall, so the pipeline advances every cycle.
`default_nettype none

module tet_shape_function_eval_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [tsfe_pkg::IN_W-1:0]    coord_r,
    input  logic signed [tsfe_pkg::IN_W-1:0]    coord_s,
    input  logic signed [tsfe_pkg::IN_W-1:0]    coord_t,
    output logic                                result_valid,
    output logic [tsfe_pkg::NODE_W-1:0]         node_index,
    output logic signed [tsfe_pkg::OUT_W-1:0]   shape_value,
    output logic signed [tsfe_pkg::OUT_W-1:0]   deriv_r,
    output logic signed [tsfe_pkg::OUT_W-1:0]   deriv_s,
    output logic signed [tsfe_pkg::OUT_W-1:0]   deriv_t,
    output logic                                last_node,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_data
);

    localparam int CW = tsfe_pkg::CW;

    logic                               mode_reg;
    logic                               active_reg, active_next;
    logic [tsfe_pkg::NODE_W-1:0]        node_reg, node_next;
    logic                               quad_reg;
    logic signed [tsfe_pkg::IN_W-1:0]   r_reg, s_reg, t_reg;
    logic signed [CW-1:0]               u_reg;
    logic signed [CW-1:0]               u_next;
    logic                               issue_last;
    logic                               accept;
    tsfe_pkg::tsfe_tag_t                issue_tag;
    tsfe_pkg::tsfe_tag_t                res_tag;

    // Mode register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            mode_reg <= cfg_data;
        end
    end

    // Node sequencer: issue one node per cycle
    assign issue_last = active_reg &&
        (node_reg == (quad_reg ? tsfe_pkg::LAST_NODE_QUAD : tsfe_pkg::LAST_NODE_LIN));
    assign busy   = active_reg && !issue_last;
    assign accept = start && !busy;
    assign u_next = tsfe_pkg::ONE_C - CW'(coord_r) - CW'(coord_s) - CW'(coord_t);

    always_comb
    begin
        active_next = active_reg;
        node_next   = node_reg;
        if (accept) begin
            active_next = 1'b1;
            node_next   = '0;
        end else if (issue_last) begin
            active_next = 1'b0;
        end else if (active_reg) begin
            node_next = node_reg + tsfe_pkg::NODE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            active_reg <= 1'b0;
            node_reg   <= '0;
            quad_reg   <= 1'b0;
        end else begin
            active_reg <= active_next;
            node_reg   <= node_next;
            if (accept) begin
                quad_reg <= mode_reg;
            end
        end
    end

    // Hold the request coordinates
    always_ff @(posedge clk)
    begin
        if (accept) begin
            r_reg <= coord_r;
            s_reg <= coord_s;
            t_reg <= coord_t;
            u_reg <= u_next;
        end
    end

    assign issue_tag = '{node: node_reg, last: issue_last, quad: quad_reg};

    tsfe_node_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (active_reg),
        .in_tag    (issue_tag),
        .r         (r_reg),
        .s         (s_reg),
        .t         (t_reg),
        .u         (u_reg),
        .out_valid (result_valid),
        .out_tag   (res_tag),
        .out_n     (shape_value),
        .out_dr    (deriv_r),
        .out_ds    (deriv_s),
        .out_dt    (deriv_t)
    );

    assign node_index = res_tag.node;
    assign last_node  = res_tag.last;

    // The last result of a request is node 3 or node 9
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_node) |->
            (node_index == tsfe_pkg::LAST_NODE_LIN || node_index == tsfe_pkg::LAST_NODE_QUAD))
        else $error("last_node on a wrong node");

    // Results of one request come in consecutive cycles in node order
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_node) |=>
            (result_valid && node_index == $past(node_index) + tsfe_pkg::NODE_W'(1)))
        else $error("node results not contiguous");

    // An accepted request is followed in turn by a valid result for node 0
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 (result_valid && node_index == '0))
        else $error("first node result late or missing");

endmodule

`default_nettype wire

@@ hw/rtl/tsfe_node_pipe.sv @@
`default_nettype none

module tsfe_node_pipe (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  tsfe_pkg::tsfe_tag_t                 in_tag,
    input  logic signed [tsfe_pkg::IN_W-1:0]    r,
    input  logic signed [tsfe_pkg::IN_W-1:0]    s,
    input  logic signed [tsfe_pkg::IN_W-1:0]    t,
    input  logic signed [tsfe_pkg::CW-1:0]      u,
    output logic                                out_valid,
    output tsfe_pkg::tsfe_tag_t                 out_tag,
    output logic signed [tsfe_pkg::OUT_W-1:0]   out_n,
    output logic signed [tsfe_pkg::OUT_W-1:0]   out_dr,
    output logic signed [tsfe_pkg::OUT_W-1:0]   out_ds,
    output logic signed [tsfe_pkg::OUT_W-1:0]   out_dt
);

    localparam int OW = tsfe_pkg::OW;
    localparam int DW = tsfe_pkg::DW;
    localparam int PW = tsfe_pkg::PW;

    // Stage 1: operand select and derivatives
    logic                   v1_reg;
    tsfe_pkg::tsfe_tag_t    tag1_reg;
    logic signed [OW-1:0]   a1_reg, a1_next;
    logic signed [OW-1:0]   b1_reg, b1_next;
    logic                   sc1_reg, sc1_next;
    logic signed [DW-1:0]   dr1_reg, dr1_next;
    logic signed [DW-1:0]   ds1_reg, ds1_next;
    logic signed [DW-1:0]   dt1_reg, dt1_next;

    logic signed [OW-1:0] ro, so, to, uo, one_o;
    logic signed [DW-1:0] rd, sd, td, ud, one_d;

    assign ro    = OW'(r);
    assign so    = OW'(s);
    assign to    = OW'(t);
    assign uo    = OW'(u);
    assign one_o = OW'(tsfe_pkg::ONE_C);
    assign rd    = DW'(r);
    assign sd    = DW'(s);
    assign td    = DW'(t);
    assign ud    = DW'(u);
    assign one_d = DW'(tsfe_pkg::ONE_C);

    // Pick product operands and derivatives for the node
    always_comb
    begin
        a1_next  = '0;
        b1_next  = one_o;
        sc1_next = 1'b0;
        dr1_next = '0;
        ds1_next = '0;
        dt1_next = '0;
        if (!in_tag.quad) begin
            case (in_tag.node)
                4'd0:
                begin
                    a1_next  = ro;
                    dr1_next = one_d;
                end
                4'd1:
                begin
                    a1_next  = so;
                    ds1_next = one_d;
                end
                4'd2:
                begin
                    a1_next  = uo;
                    dr1_next = -one_d;
                    ds1_next = -one_d;
                    dt1_next = -one_d;
                end
                4'd3:
                begin
                    a1_next  = to;
                    dt1_next = one_d;
                end
                default:
                begin
                    a1_next = '0;
                end
            endcase
        end else begin
            case (in_tag.node)
                4'd0:
                begin
                    a1_next  = ro;
                    b1_next  = (ro <<< 1) - one_o;
                    dr1_next = (rd <<< 2) - one_d;
                end
                4'd1:
                begin
                    a1_next  = so;
                    b1_next  = (so <<< 1) - one_o;
                    ds1_next = (sd <<< 2) - one_d;
                end
                4'd2:
                begin
                    a1_next  = uo;
                    b1_next  = (uo <<< 1) - one_o;
                    dr1_next = one_d - (ud <<< 2);
                    ds1_next = one_d - (ud <<< 2);
                    dt1_next = one_d - (ud <<< 2);
                end
                4'd3:
                begin
                    a1_next  = to;
                    b1_next  = (to <<< 1) - one_o;
                    dt1_next = (td <<< 2) - one_d;
                end
                4'd4:
                begin
                    a1_next  = ro;
                    b1_next  = so;
                    sc1_next = 1'b1;
                    dr1_next = sd <<< 2;
                    ds1_next = rd <<< 2;
                end
                4'd5:
                begin
                    a1_next  = so;
                    b1_next  = uo;
                    sc1_next = 1'b1;
                    dr1_next = -(sd <<< 2);
                    ds1_next = (ud - sd) <<< 2;
                    dt1_next = -(sd <<< 2);
                end
                4'd6:
                begin
                    a1_next  = ro;
                    b1_next  = uo;
                    sc1_next = 1'b1;
                    dr1_next = (ud - rd) <<< 2;
                    ds1_next = -(rd <<< 2);
                    dt1_next = -(rd <<< 2);
                end
                4'd7:
                begin
                    a1_next  = ro;
                    b1_next  = to;
                    sc1_next = 1'b1;
                    dr1_next = td <<< 2;
                    dt1_next = rd <<< 2;
                end
                4'd8:
                begin
                    a1_next  = so;
                    b1_next  = to;
                    sc1_next = 1'b1;
                    ds1_next = td <<< 2;
                    dt1_next = sd <<< 2;
                end
                4'd9:
                begin
                    a1_next  = to;
                    b1_next  = uo;
                    sc1_next = 1'b1;
                    dr1_next = -(td <<< 2);
                    ds1_next = -(td <<< 2);
                    dt1_next = (ud - td) <<< 2;
                end
                default:
                begin
                    a1_next = '0;
                end
            endcase
        end
    end

    // Stage 2: multiply, clamp derivatives
    logic                           v2_reg;
    tsfe_pkg::tsfe_tag_t            tag2_reg;
    logic signed [2*OW-1:0]         prod2_reg;
    logic                           sc2_reg;
    logic signed [tsfe_pkg::OUT_W-1:0] dr2_reg, ds2_reg, dt2_reg;
    logic signed [2*OW-1:0]         prod2_next;

    assign prod2_next = a1_reg * b1_reg;

    // Stage 3: scale, round to nearest with ties up, clamp
    logic signed [PW-1:0] prod_ext, prod_sc, prod_rnd, n_full;

    assign prod_ext = PW'(prod2_reg);
    assign prod_sc  = sc2_reg ? (prod_ext <<< 2) : prod_ext;
    assign prod_rnd = prod_sc + tsfe_pkg::HALF_P;
    assign n_full   = prod_rnd >>> tsfe_pkg::FRAC_BITS;

    // Advance valid bits every cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            out_valid <= 1'b0;
        end else begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            out_valid <= v2_reg;
        end
    end

    // Advance payload every cycle
    always_ff @(posedge clk)
    begin
        tag1_reg  <= in_tag;
        a1_reg    <= a1_next;
        b1_reg    <= b1_next;
        sc1_reg   <= sc1_next;
        dr1_reg   <= dr1_next;
        ds1_reg   <= ds1_next;
        dt1_reg   <= dt1_next;

        tag2_reg  <= tag1_reg;
        prod2_reg <= prod2_next;
        sc2_reg   <= sc1_reg;
        dr2_reg   <= tsfe_pkg::sat_out(PW'(dr1_reg));
        ds2_reg   <= tsfe_pkg::sat_out(PW'(ds1_reg));
        dt2_reg   <= tsfe_pkg::sat_out(PW'(dt1_reg));

        out_tag   <= tag2_reg;
        out_n     <= tsfe_pkg::sat_out(n_full);
        out_dr    <= dr2_reg;
        out_ds    <= ds2_reg;
        out_dt    <= dt2_reg;
    end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_LINEAR = 1'b0;
    localparam logic MODE_QUAD   = 1'b1;
    localparam int   IDLE_LIMIT  = 2000;
    localparam int   REPORT_MAX  = 10;

    typedef struct packed {
        logic signed [tsfe_pkg::IN_W-1:0] r;
        logic signed [tsfe_pkg::IN_W-1:0] s;
        logic signed [tsfe_pkg::IN_W-1:0] t;
    } coord_req_t;

    typedef struct packed {
        logic [tsfe_pkg::NODE_W-1:0]       node;
        logic signed [tsfe_pkg::OUT_W-1:0] shape;
        logic signed [tsfe_pkg::OUT_W-1:0] dr;
        logic signed [tsfe_pkg::OUT_W-1:0] ds;
        logic signed [tsfe_pkg::OUT_W-1:0] dt;
        logic                              last;
    } node_result_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic signed [tsfe_pkg::IN_W-1:0]  coord_r = '0;
    logic signed [tsfe_pkg::IN_W-1:0]  coord_s = '0;
    logic signed [tsfe_pkg::IN_W-1:0]  coord_t = '0;
    logic                              result_valid;
    logic [tsfe_pkg::NODE_W-1:0]       node_index;
    logic signed [tsfe_pkg::OUT_W-1:0] shape_value;
    logic signed [tsfe_pkg::OUT_W-1:0] deriv_r;
    logic signed [tsfe_pkg::OUT_W-1:0] deriv_s;
    logic signed [tsfe_pkg::OUT_W-1:0] deriv_t;
    logic                              last_node;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic                              cfg_data = 1'b0;

    coord_req_t   coord_pending[$];
    node_result_t node_results_due[$];
    logic         elem_mode = MODE_LINEAR;
    bit           steady = 1'b0;
    logic [3:0]   send_gap = '0;
    int           mismatch_count = 0;
    int           req_count = 0;
    int           result_count = 0;
    int           mode_writes = 0;
    int           idle_cycles = 0;

    tet_shape_function_eval_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .coord_r      (coord_r),
        .coord_s      (coord_s),
        .coord_t      (coord_t),
        .result_valid (result_valid),
        .node_index   (node_index),
        .shape_value  (shape_value),
        .deriv_r      (deriv_r),
        .deriv_s      (deriv_s),
        .deriv_t      (deriv_t),
        .last_node    (last_node),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Round a product with twice the fraction bits back to the output scale, ties upward
    function automatic longint round_prod(input longint x);
        return (x + (longint'(1) <<< (tsfe_pkg::FRAC_BITS - 1))) >>> tsfe_pkg::FRAC_BITS;
    endfunction

    // Clamp to the output range
    function automatic logic signed [tsfe_pkg::OUT_W-1:0] clamp_out(input longint v);
        longint lo;
        longint hi;
        lo = -(longint'(1) <<< (tsfe_pkg::OUT_W - 1));
        hi = (longint'(1) <<< (tsfe_pkg::OUT_W - 1)) - 1;
        if (v > hi)
            v = hi;
        if (v < lo)
            v = lo;
        return v[tsfe_pkg::OUT_W-1:0];
    endfunction

    // Compute every node result of one request and queue it up
    function automatic void predict_nodes(input coord_req_t req);
        longint one, r, s, t, u, g;
        longint nv[10], dr[10], ds[10], dt[10];
        int last, k;
        node_result_t res;
        one = longint'(1) <<< tsfe_pkg::FRAC_BITS;
        r = req.r;
        s = req.s;
        t = req.t;
        u = one - r - s - t;
        for (k = 0; k < 10; k++)
        begin
            nv[k] = 0;
            dr[k] = 0;
            ds[k] = 0;
            dt[k] = 0;
        end
        if (elem_mode == MODE_LINEAR)
        begin
            last = int'(tsfe_pkg::LAST_NODE_LIN);
            nv[0] = r; dr[0] = one;
            nv[1] = s; ds[1] = one;
            nv[2] = u; dr[2] = -one; ds[2] = -one; dt[2] = -one;
            nv[3] = t; dt[3] = one;
        end
        else
        begin
            last = int'(tsfe_pkg::LAST_NODE_QUAD);
            g = 4 * (r + s + t) - 3 * one;
            nv[0] = round_prod(r * (2 * r - one));
            nv[1] = round_prod(s * (2 * s - one));
            nv[2] = round_prod(u * (2 * u - one));
            nv[3] = round_prod(t * (2 * t - one));
            nv[4] = round_prod(4 * r * s);
            nv[5] = round_prod(4 * s * u);
            nv[6] = round_prod(4 * r * u);
            nv[7] = round_prod(4 * r * t);
            nv[8] = round_prod(4 * s * t);
            nv[9] = round_prod(4 * t * u);
            dr[0] = 4 * r - one;
            ds[1] = 4 * s - one;
            dr[2] = g; ds[2] = g; dt[2] = g;
            dt[3] = 4 * t - one;
            dr[4] = 4 * s;  ds[4] = 4 * r;
            dr[5] = -4 * s; ds[5] = -4 * (r + 2 * s + t - one); dt[5] = -4 * s;
            dr[6] = -4 * (2 * r + s + t - one); ds[6] = -4 * r; dt[6] = -4 * r;
            dr[7] = 4 * t;  dt[7] = 4 * r;
            ds[8] = 4 * t;  dt[8] = 4 * s;
            dr[9] = -4 * t; ds[9] = -4 * t; dt[9] = -4 * (r + s + 2 * t - one);
        end
        for (k = 0; k <= last; k++)
        begin
            res.node  = tsfe_pkg::NODE_W'(k);
            res.shape = clamp_out(nv[k]);
            res.dr    = clamp_out(dr[k]);
            res.ds    = clamp_out(ds[k]);
            res.dt    = clamp_out(dt[k]);
            res.last  = (k == last);
            node_results_due.push_back(res);
        end
    endfunction

    function automatic coord_req_t make_req(input int r, input int s, input int t);
        coord_req_t req;
        req.r = r[tsfe_pkg::IN_W-1:0];
        req.s = s[tsfe_pkg::IN_W-1:0];
        req.t = t[tsfe_pkg::IN_W-1:0];
        return req;
    endfunction

    // Vertices, extremes, mid-edge points and rounding ties
    task automatic add_directed();
        int one;
        int pmax;
        int pmin;
        one  = 1 << tsfe_pkg::FRAC_BITS;
        pmax = (1 << (tsfe_pkg::IN_W - 1)) - 1;
        pmin = -(1 << (tsfe_pkg::IN_W - 1));
        coord_pending.push_back(make_req(0, 0, 0));
        coord_pending.push_back(make_req(one, 0, 0));
        coord_pending.push_back(make_req(0, one, 0));
        coord_pending.push_back(make_req(0, 0, one));
        coord_pending.push_back(make_req(one / 2, one / 2, 0));
        coord_pending.push_back(make_req(one / 4, one / 4, one / 4));
        coord_pending.push_back(make_req(pmax, pmax, pmax));
        coord_pending.push_back(make_req(pmin, pmin, pmin));
        coord_pending.push_back(make_req(pmax, pmin, 0));
        coord_pending.push_back(make_req(1, one / 8, 0));
        coord_pending.push_back(make_req(-1, one / 8, 0));
        coord_pending.push_back(make_req(pmin, pmax, pmin));
    endtask

    // Mostly points inside the element, the rest across the field range, near zero or within +/- one
    task automatic add_random(input int count);
        int one;
        int r, s, t;
        int kind;
        one = 1 << tsfe_pkg::FRAC_BITS;
        repeat (count)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 6)
            begin
                r = $urandom_range(0, one);
                s = $urandom_range(0, one - r);
                t = $urandom_range(0, one - r - s);
            end
            else if (kind < 8)
            begin
                r = $urandom_range(0, (1 << tsfe_pkg::IN_W) - 1);
                s = $urandom_range(0, (1 << tsfe_pkg::IN_W) - 1);
                t = $urandom_range(0, (1 << tsfe_pkg::IN_W) - 1);
            end
            else if (kind == 8)
            begin
                r = $urandom_range(0, 64) - 32;
                s = $urandom_range(0, 64) - 32;
                t = $urandom_range(0, 64) - 32;
            end
            else
            begin
                r = $urandom_range(0, 2 * one) - one;
                s = $urandom_range(0, 2 * one) - one;
                t = $urandom_range(0, 2 * one) - one;
            end
            coord_pending.push_back(make_req(r, s, t));
        end
    endtask

    // Hold until every request is sent and every node result is back, then let the pipe drain
    task automatic wait_idle();
        do
            @(negedge clk);
        while (coord_pending.size() != 0 || start || node_results_due.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_mode(input logic mode);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        elem_mode = mode;
        mode_writes++;
        cfg_valid <= 1'b0;
    endtask

    // Request driver: hold start until accepted, then wait the drawn gap
    always @(posedge clk or negedge rst_n)
    begin
        coord_req_t req;
        if (!rst_n)
        begin
            start    <= 1'b0;
            send_gap <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_nodes({coord_r, coord_s, coord_t});
                req_count++;
            end
            if (!start || !busy)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1'b1;
                    start    <= 1'b0;
                end
                else if (coord_pending.size() != 0)
                begin
                    req = coord_pending.pop_front();
                    coord_r  <= req.r;
                    coord_s  <= req.s;
                    coord_t  <= req.t;
                    start    <= 1'b1;
                    send_gap <= steady ? 4'd0 : 4'($urandom_range(0, 12));
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare against the oldest outstanding node result
    always @(posedge clk or negedge rst_n)
    begin
        node_result_t got;
        node_result_t want;
        if (rst_n && result_valid)
        begin
            got = {node_index, shape_value, deriv_r, deriv_s, deriv_t, last_node};
            result_count++;
            if (node_results_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result: node %0d N %0d dr %0d ds %0d dt %0d last %0b",
                             got.node, got.shape, got.dr, got.ds, got.dt, got.last);
            end
            else
            begin
                want = node_results_due.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                    begin
                        $display("mismatch exp: node %0d N %0d dr %0d ds %0d dt %0d last %0b",
                                 want.node, want.shape, want.dr, want.ds, want.dt, want.last);
                        $display("         got: node %0d N %0d dr %0d ds %0d dt %0d last %0b",
                                 got.node, got.shape, got.dr, got.ds, got.dt, got.last);
                    end
                end
            end
        end
    end

    // Watchdog: stop when nothing moves for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog expired with %0d node results outstanding",
                     node_results_due.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Linear element straight out of reset
        add_directed();
        wait_idle();

        // Quadratic element, directed then random
        write_mode(MODE_QUAD);
        add_directed();
        add_random(40);
        wait_idle();

        // Back to linear, back-to-back requests
        write_mode(MODE_LINEAR);
        steady = 1'b1;
        add_random(32);
        wait_idle();

        // Quadratic with random gaps
        write_mode(MODE_QUAD);
        steady = 1'b0;
        add_random(32);
        wait_idle();

        // Rewrite the same mode, then run without gaps
        write_mode(MODE_QUAD);
        steady = 1'b1;
        add_random(32);
        wait_idle();

        $display("ran %0d coordinate requests, %0d node results, %0d mode writes",
                 req_count, result_count, mode_writes);
        $display("linear and quadratic elements, vertices, range extremes and rounding ties");
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
        begin
            $display("%0d mismatches", mismatch_count);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
hw/rtl/tsfe_pkg.sv
hw/rtl/tsfe_node_pipe.sv
hw/rtl/tet_shape_function_eval_core.sv
tb/testbench.sv
